@@ rtl/ncc_pkg.sv @@
// Package for the normal cone cull test core.
// Shared types, codes and fixed-point constants; no dependencies.
`timescale 1ns / 1ps

package ncc_pkg;

  // Register stages from input capture to the output register.
  localparam int NUM_STAGES = 11;

  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  // Pipeline control that the datapath modules follow.
  typedef struct packed {
    stage_vec_t en;   // stage register loads this cycle
    stage_vec_t vld;  // stage register holds a live request
  } pipe_ctl_t;

  // Test kinds.
  typedef enum logic {
    OP_BACKFACE  = 1'b0,
    OP_FRONTFACE = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_VIEW_X = 2'd0,
    CFG_VIEW_Y = 2'd1,
    CFG_VIEW_Z = 2'd2
  } cfg_idx_t;

  // Geometry results handed to the wide arithmetic back end.
  typedef struct packed {
    logic        sign_ok;  // sign of the cone term matches the test kind
    logic [15:0] spmag;    // |spread|
    logic [64:0] smag;     // |sum(D * axis)|
    logic [96:0] q;        // sum(D * D)
  } geom_t;

  // Threshold term: 1000 * F >= 32766^2 * 3276 * 65536 becomes F >= F_MIN.
  localparam logic [63:0] CULL_K =
    64'd32766 * 64'd32766 * 64'd3276 * 64'd65536;
  localparam logic [63:0] F_MIN = (CULL_K + 64'd999) / 64'd1000;

  // Scale of the squared comparison: M^2 with M = 32766 * 3276.
  localparam logic [63:0] CULL_M   = 64'd32766 * 64'd3276;
  localparam logic [63:0] CULL_M2  = CULL_M * CULL_M;
  localparam logic [53:0] M2       = CULL_M2[53:0];
  localparam logic [26:0] M2_LO    = CULL_M2[26:0];
  localparam logic [26:0] M2_HI    = CULL_M2[53:27];

endpackage

@@ rtl/ncc_ctrl.sv @@
// Pipeline control for the normal cone cull test core.
// Valid bits and stage load enables; uses ncc_pkg.
`timescale 1ns / 1ps

module ncc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output ncc_pkg::pipe_ctl_t ctl
);

  ncc_pkg::stage_vec_t vld_r;
  ncc_pkg::stage_vec_t vld_nxt;
  ncc_pkg::stage_vec_t en;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[ncc_pkg::NUM_STAGES-1] = !vld_r[ncc_pkg::NUM_STAGES-1] || !out_stall;
    for (int k = ncc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  // Valid bits travel with the data.
  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < ncc_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[ncc_pkg::NUM_STAGES-1];
  assign ctl.en    = en;
  assign ctl.vld   = vld_r;

endmodule

@@ rtl/ncc_geom.sv @@
// Geometry front end of the normal cone cull test core: stages 0 to 4.
// Forms D = 32766*(centre-view) +- axis*radius, sum(D*axis) and sum(D*D); uses ncc_pkg.
`timescale 1ns / 1ps

module ncc_geom (
  input  logic               clk,
  input  ncc_pkg::pipe_ctl_t ctl,
  input  logic               in_opcode,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic signed [15:0] in_spread,
  input  logic signed [31:0] in_centre_x,
  input  logic signed [31:0] in_centre_y,
  input  logic signed [31:0] in_centre_z,
  input  logic        [30:0] in_radius,
  input  logic signed [31:0] view_x,
  input  logic signed [31:0] view_y,
  input  logic signed [31:0] view_z,
  output ncc_pkg::geom_t     geom
);

  logic signed [15:0] ax_in  [3];
  logic signed [31:0] cen_in [3];
  logic signed [31:0] vw_in  [3];

  // Stage 0: centre minus view, axis times radius.
  logic signed [32:0] e_r    [3];
  logic signed [32:0] e_nxt  [3];
  logic signed [47:0] off_r  [3];
  logic signed [47:0] off_nxt[3];
  logic signed [15:0] ax0_r  [3];
  logic signed [15:0] sp0_r;
  logic               front0_r;

  // Stage 1: anchor offset D.
  logic signed [48:0] d_r    [3];
  logic signed [48:0] d_nxt  [3];
  logic signed [15:0] ax1_r  [3];
  logic signed [15:0] sp1_r;
  logic               front1_r;

  // Stage 2: D * axis and the partial products of D * D.
  logic signed [64:0] p_r    [3];
  logic signed [64:0] p_nxt  [3];
  logic signed [33:0] hh_r   [3];
  logic signed [33:0] hh_nxt [3];
  logic signed [49:0] hl_r   [3];
  logic signed [49:0] hl_nxt [3];
  logic        [63:0] ll_r   [3];
  logic        [63:0] ll_nxt [3];
  logic signed [15:0] sp2_r;
  logic               front2_r;

  // Stage 3: dot product sum and per component squares.
  logic signed [66:0] s_r;
  logic signed [66:0] s_nxt;
  logic signed [97:0] sq_full[3];
  logic        [95:0] sq_r   [3];
  logic        [95:0] sq_nxt [3];
  logic signed [15:0] sp3_r;
  logic               front3_r;

  // Stage 4: magnitudes, sign check and the sum of squares.
  logic        [97:0] q_sum;
  logic        [66:0] s_abs;
  logic        [15:0] sp_abs;
  ncc_pkg::geom_t     geom_r;
  ncc_pkg::geom_t     geom_nxt;

  always_comb begin
    ax_in[0]  = in_axis_x;
    ax_in[1]  = in_axis_y;
    ax_in[2]  = in_axis_z;
    cen_in[0] = in_centre_x;
    cen_in[1] = in_centre_y;
    cen_in[2] = in_centre_z;
    vw_in[0]  = view_x;
    vw_in[1]  = view_y;
    vw_in[2]  = view_z;
  end

  // Stage 0 logic.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_nxt[i]   = $signed({cen_in[i][31], cen_in[i]}) - $signed({vw_in[i][31], vw_in[i]});
      off_nxt[i] = ax_in[i] * $signed({1'b0, in_radius});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      for (int i = 0; i < 3; i++) begin
        e_r[i]   <= e_nxt[i];
        off_r[i] <= off_nxt[i];
        ax0_r[i] <= ax_in[i];
      end
      sp0_r    <= in_spread;
      front0_r <= (in_opcode == ncc_pkg::OP_FRONTFACE);
    end
  end

  // Stage 1 logic: 32766*E is a shift and subtract; the radius term adds for frontface.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = ($signed({{16{e_r[i][32]}}, e_r[i]}) <<< 15)
               - ($signed({{16{e_r[i][32]}}, e_r[i]}) <<< 1)
               + (front0_r ? $signed({off_r[i][47], off_r[i]})
                           : -$signed({off_r[i][47], off_r[i]}));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= d_nxt[i];
        ax1_r[i] <= ax0_r[i];
      end
      sp1_r    <= sp0_r;
      front1_r <= front0_r;
    end
  end

  // Stage 2 logic: D splits into a signed high part and an unsigned low word.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_nxt[i]  = d_r[i] * ax1_r[i];
      hh_nxt[i] = $signed(d_r[i][48:32]) * $signed(d_r[i][48:32]);
      hl_nxt[i] = $signed(d_r[i][48:32]) * $signed({1'b0, d_r[i][31:0]});
      ll_nxt[i] = d_r[i][31:0] * d_r[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i]  <= p_nxt[i];
        hh_r[i] <= hh_nxt[i];
        hl_r[i] <= hl_nxt[i];
        ll_r[i] <= ll_nxt[i];
      end
      sp2_r    <= sp1_r;
      front2_r <= front1_r;
    end
  end

  // Stage 3 logic: D^2 = hh*2^64 + 2*hl*2^32 + ll, never negative.
  always_comb begin
    s_nxt = $signed({{2{p_r[0][64]}}, p_r[0]})
          + $signed({{2{p_r[1][64]}}, p_r[1]})
          + $signed({{2{p_r[2][64]}}, p_r[2]});
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = ($signed({{64{hh_r[i][33]}}, hh_r[i]}) <<< 64)
                 + ($signed({{48{hl_r[i][49]}}, hl_r[i]}) <<< 33)
                 + $signed({34'd0, ll_r[i]});
      sq_nxt[i]  = sq_full[i][95:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s_r <= s_nxt;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= sq_nxt[i];
      end
      sp3_r    <= sp2_r;
      front3_r <= front2_r;
    end
  end

  // Stage 4 logic: F = s * spread * S is positive when the three signs agree.
  always_comb begin
    q_sum  = 98'(sq_r[0]) + 98'(sq_r[1]) + 98'(sq_r[2]);
    s_abs  = s_r[66] ? (~s_r + 67'd1) : s_r;
    sp_abs = sp3_r[15] ? (~sp3_r + 16'd1) : sp3_r;
    geom_nxt.sign_ok = ~(s_r[66] ^ sp3_r[15] ^ front3_r);
    geom_nxt.spmag   = sp_abs;
    geom_nxt.smag    = s_abs[64:0];
    geom_nxt.q       = q_sum[96:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      geom_r <= geom_nxt;
    end
  end

  assign geom = geom_r;

endmodule

@@ rtl/ncc_wide.sv @@
// Wide arithmetic back end of the normal cone cull test core: stages 5 to 10.
// Builds F, F*F and Q*M^2 from 32-bit partial products and compares; uses ncc_pkg.
`timescale 1ns / 1ps

module ncc_wide (
  input  logic               clk,
  input  ncc_pkg::pipe_ctl_t ctl,
  input  ncc_pkg::geom_t     geom,
  output logic               facing
);

  // Stage 5: partial products of F and of Q * M^2.
  logic [48:0]  fh_r;
  logic [48:0]  fh_nxt;
  logic [47:0]  fl_r;
  logic [47:0]  fl_nxt;
  logic [58:0]  qlo_r  [3];
  logic [58:0]  qlo_nxt[3];
  logic [58:0]  qhi_r  [3];
  logic [58:0]  qhi_nxt[3];
  logic [53:0]  r3_5_r;
  logic         sok5_r;

  // Stage 6: F and the per word products of Q * M^2.
  logic [80:0]  f_sum;
  logic [79:0]  f_r;
  logic [85:0]  r_r    [3];
  logic [85:0]  r_nxt  [3];
  logic [53:0]  r3_6_r;
  logic         sok6_r;

  // Stage 7: partial products of F * F, threshold check, first Q*M^2 merge.
  logic [63:0]  p00_r, p01_r, p11_r;
  logic [47:0]  p02_r, p12_r;
  logic [31:0]  p22_r;
  logic [118:0] a_r;
  logic [86:0]  b_r;
  logic         ge7_r;
  logic         sok7_r;

  // Stage 8: F * F in three slices, Q * M^2 complete.
  logic [97:0]  lo_r;
  logic [64:0]  mid_r;
  logic [64:0]  hi_r;
  logic [151:0] qm8_r;
  logic         ge8_r;
  logic         sok8_r;

  // Stage 9: F * F complete.
  logic [160:0] ff_r;
  logic [151:0] qm9_r;
  logic         ge9_r;
  logic         sok9_r;

  // Stage 10: the result register.
  logic         facing_r;
  logic         facing_nxt;

  // Stage 5 logic: |S| splits at bit 32, Q splits in 32-bit words, M^2 in halves.
  always_comb begin
    fh_nxt = geom.smag[64:32] * geom.spmag;
    fl_nxt = geom.smag[31:0] * geom.spmag;
    for (int j = 0; j < 3; j++) begin
      qlo_nxt[j] = geom.q[32*j +: 32] * ncc_pkg::M2_LO;
      qhi_nxt[j] = geom.q[32*j +: 32] * ncc_pkg::M2_HI;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      fh_r <= fh_nxt;
      fl_r <= fl_nxt;
      for (int j = 0; j < 3; j++) begin
        qlo_r[j] <= qlo_nxt[j];
        qhi_r[j] <= qhi_nxt[j];
      end
      r3_5_r <= geom.q[96] ? ncc_pkg::M2 : '0;
      sok5_r <= geom.sign_ok;
    end
  end

  // Stage 6 logic.
  always_comb begin
    f_sum = (81'(fh_r) << 32) + 81'(fl_r);
    for (int j = 0; j < 3; j++) begin
      r_nxt[j] = 86'(qlo_r[j]) + (86'(qhi_r[j]) << 27);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      f_r <= f_sum[79:0];
      for (int j = 0; j < 3; j++) begin
        r_r[j] <= r_nxt[j];
      end
      r3_6_r <= r3_5_r;
      sok6_r <= sok5_r;
    end
  end

  // Stage 7: F splits into two 32-bit words and a 16-bit top.
  always_ff @(posedge clk) begin
    if (ctl.en[7]) begin
      p00_r  <= f_r[31:0] * f_r[31:0];
      p01_r  <= f_r[31:0] * f_r[63:32];
      p11_r  <= f_r[63:32] * f_r[63:32];
      p02_r  <= f_r[31:0] * f_r[79:64];
      p12_r  <= f_r[63:32] * f_r[79:64];
      p22_r  <= f_r[79:64] * f_r[79:64];
      ge7_r  <= (f_r >= 80'(ncc_pkg::F_MIN));
      a_r    <= 119'(r_r[0]) + (119'(r_r[1]) << 32);
      b_r    <= 87'(r_r[2]) + (87'(r3_6_r) << 32);
      sok7_r <= sok6_r;
    end
  end

  // Stage 8: cross terms count twice, hence the extra shift by one.
  always_ff @(posedge clk) begin
    if (ctl.en[8]) begin
      lo_r   <= 98'(p00_r) + (98'(p01_r) << 33);
      mid_r  <= 65'(p11_r) + (65'(p02_r) << 1);
      hi_r   <= (65'(p12_r) << 1) + (65'(p22_r) << 32);
      qm8_r  <= 152'(a_r) + (152'(b_r) << 64);
      ge8_r  <= ge7_r;
      sok8_r <= sok7_r;
    end
  end

  // Stage 9: slices sit at 2^0, 2^64 and 2^96.
  always_ff @(posedge clk) begin
    if (ctl.en[9]) begin
      ff_r   <= 161'(lo_r) + (161'(mid_r) << 64) + (161'(hi_r) << 96);
      qm9_r  <= qm8_r;
      ge9_r  <= ge8_r;
      sok9_r <= sok8_r;
    end
  end

  // Stage 10: both comparisons pass on equality.
  assign facing_nxt = sok9_r && ge9_r && (ff_r >= 161'(qm9_r));

  always_ff @(posedge clk) begin
    if (ctl.en[10]) begin
      facing_r <= facing_nxt;
    end
  end

  assign facing = facing_r;

endmodule

@@ rtl/normal_cone_cull_test_core.sv @@
// Normal cone cull test core: top level with viewpoint registers and assertions.
// Uses ncc_pkg, ncc_ctrl, ncc_geom and ncc_wide.
// The pipeline has 11 register stages, from input capture to the output register.
// Throughput: one request per cycle unless the pipeline is full and the result stalls; the
// output register and per-stage valid bits let the pipeline fill up behind a stalled result.
// Reset (synchronous, active low) empties the pipeline and clears the viewpoint to zero.
`timescale 1ns / 1ps

module normal_cone_cull_test_core (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  // Request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic signed [15:0] in_spread,
  input  logic signed [31:0] in_centre_x,
  input  logic signed [31:0] in_centre_y,
  input  logic signed [31:0] in_centre_z,
  input  logic        [30:0] in_radius,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_facing
);

  logic signed [31:0] view_x_r, view_x_nxt;
  logic signed [31:0] view_y_r, view_y_nxt;
  logic signed [31:0] view_z_r, view_z_nxt;

  ncc_pkg::pipe_ctl_t ctl;
  ncc_pkg::geom_t     geom;

  // Viewpoint register writes; unused indexes are ignored.
  always_comb begin
    view_x_nxt = view_x_r;
    view_y_nxt = view_y_r;
    view_z_nxt = view_z_r;
    if (cfg_we) begin
      case (cfg_index)
        ncc_pkg::CFG_VIEW_X: view_x_nxt = cfg_wdata;
        ncc_pkg::CFG_VIEW_Y: view_y_nxt = cfg_wdata;
        ncc_pkg::CFG_VIEW_Z: view_z_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_x_r <= '0;
      view_y_r <= '0;
      view_z_r <= '0;
    end else begin
      view_x_r <= view_x_nxt;
      view_y_r <= view_y_nxt;
      view_z_r <= view_z_nxt;
    end
  end

  // Handshake and stage enables.
  ncc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  // Geometry front end.
  ncc_geom u_geom (
    .clk         (clk),
    .ctl         (ctl),
    .in_opcode   (in_opcode),
    .in_axis_x   (in_axis_x),
    .in_axis_y   (in_axis_y),
    .in_axis_z   (in_axis_z),
    .in_spread   (in_spread),
    .in_centre_x (in_centre_x),
    .in_centre_y (in_centre_y),
    .in_centre_z (in_centre_z),
    .in_radius   (in_radius),
    .view_x      (view_x_r),
    .view_y      (view_y_r),
    .view_z      (view_z_r),
    .geom        (geom)
  );

  // Wide products and final comparisons.
  ncc_wide u_wide (
    .clk    (clk),
    .ctl    (ctl),
    .geom   (geom),
    .facing (out_facing)
  );

`ifndef NO_ASSERTIONS
  // The request side only stalls when every stage holds a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&ctl.vld))
    else $error("request stalled while the pipeline has a free stage");

  // Without back pressure on the result side the request side never stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("request stalled without result back pressure");

  // An accepted request with no result leaving adds exactly one live stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !(out_valid && !out_stall))
      |=> ($countones(ctl.vld) == $past($countones(ctl.vld)) + 1))
    else $error("request lost or duplicated in the pipeline");
`endif

endmodule

@@ verif/ncc_cull_checker.sv @@
// Checker for the normal cone cull test core: watches both channels and the config port.
// Predicts each facing result with exact wide arithmetic; depends on ncc_pkg.
`timescale 1ns / 1ps

module ncc_cull_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_opcode,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic signed [15:0] in_spread,
  input  logic signed [31:0] in_centre_x,
  input  logic signed [31:0] in_centre_y,
  input  logic signed [31:0] in_centre_z,
  input  logic        [30:0] in_radius,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_facing,
  output int                 err_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 facing_count
);

  // Wide enough for F * F and Q * M^2 without overflow.
  typedef logic signed [255:0] wide_t;

  localparam wide_t CONE_K  = wide_t'(32766) * 32766 * 3276 * 65536;
  localparam wide_t CONE_M2 = wide_t'(32766) * 3276 * 32766 * 3276;

  // Local copy of the viewpoint registers.
  logic signed [31:0] view_x;
  logic signed [31:0] view_y;
  logic signed [31:0] view_z;

  // Facing results predicted for accepted requests, oldest first.
  bit facing_q[$];
  bit facing_exp;

  // Exact facing decision for one request against the current viewpoint.
  function automatic bit cone_faces(input logic opc,
                                    input logic signed [15:0] axx, axy, axz, spr,
                                    input logic signed [31:0] cnx, cny, cnz,
                                    input logic [30:0] rad);
    wide_t axis_w [3];
    wide_t cen_w [3];
    wide_t view_w [3];
    wide_t rad_w, spr_w, d_w, dot_w, len2_w, f_w;
    bit    front;
    front     = (opc == ncc_pkg::OP_FRONTFACE);
    axis_w[0] = wide_t'(axx);
    axis_w[1] = wide_t'(axy);
    axis_w[2] = wide_t'(axz);
    cen_w[0]  = wide_t'(cnx);
    cen_w[1]  = wide_t'(cny);
    cen_w[2]  = wide_t'(cnz);
    view_w[0] = wide_t'(view_x);
    view_w[1] = wide_t'(view_y);
    view_w[2] = wide_t'(view_z);
    rad_w     = wide_t'(rad);
    spr_w     = wide_t'(spr);
    dot_w     = '0;
    len2_w    = '0;
    // The anchor moves against the axis for backface, along it for frontface.
    for (int i = 0; i < 3; i++) begin
      d_w = wide_t'(32766) * (cen_w[i] - view_w[i]);
      if (front) begin
        d_w = d_w + axis_w[i] * rad_w;
      end else begin
        d_w = d_w - axis_w[i] * rad_w;
      end
      dot_w  = dot_w + d_w * axis_w[i];
      len2_w = len2_w + d_w * d_w;
    end
    f_w = dot_w * spr_w;
    if (front) begin
      f_w = -f_w;
    end
    return (f_w > wide_t'(0)) && (f_w * wide_t'(1000) >= CONE_K)
        && (f_w * f_w >= len2_w * CONE_M2);
  endfunction

  // Compare results first, then predict newly accepted requests, then track writes.
  always @(posedge clk) begin
    if (!rst_n) begin
      view_x <= '0;
      view_y <= '0;
      view_z <= '0;
      facing_q.delete();
      err_count     <= 0;
      pending_count <= 0;
      result_count  <= 0;
      facing_count  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (out_facing === 1'b1) begin
          facing_count <= facing_count + 1;
        end
        if (facing_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual facing=%b",
                   $time, out_facing);
          err_count <= err_count + 1;
        end else begin
          facing_exp = facing_q.pop_front();
          if (out_facing !== facing_exp) begin
            $display("%0t: facing mismatch: expected %b, actual %b",
                     $time, facing_exp, out_facing);
            err_count <= err_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        facing_q.push_back(cone_faces(in_opcode, in_axis_x, in_axis_y, in_axis_z,
                                      in_spread, in_centre_x, in_centre_y,
                                      in_centre_z, in_radius));
      end
      if (cfg_we) begin
        case (ncc_pkg::cfg_idx_t'(cfg_index))
          ncc_pkg::CFG_VIEW_X: view_x <= cfg_wdata;
          ncc_pkg::CFG_VIEW_Y: view_y <= cfg_wdata;
          ncc_pkg::CFG_VIEW_Z: view_z <= cfg_wdata;
          default: ;
        endcase
      end
      pending_count <= facing_q.size();
    end
  end

endmodule

@@ verif/tb_normal_cone_cull_test_core.sv @@
// Testbench top for the normal cone cull test core: clock, reset, stimulus and verdict.
// Depends on ncc_pkg, the core under test and ncc_cull_checker.
`timescale 1ns / 1ps

module tb_normal_cone_cull_test_core;

  localparam int LATENCY         = 10;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 170;

  typedef struct {
    ncc_pkg::op_t       op;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] sp;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic        [30:0] rad;
  } cone_req_t;

  typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_BLOCK} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               in_opcode;
  logic signed [15:0] in_axis_x;
  logic signed [15:0] in_axis_y;
  logic signed [15:0] in_axis_z;
  logic signed [15:0] in_spread;
  logic signed [31:0] in_centre_x;
  logic signed [31:0] in_centre_y;
  logic signed [31:0] in_centre_z;
  logic        [30:0] in_radius;
  logic               out_valid;
  logic               out_stall;
  logic               out_facing;

  int err_count;
  int pending_count;
  int result_count;
  int facing_count;

  logic signed [31:0] view_cur [3];
  cone_req_t          directed_q[$];
  int                 burst_left;
  int                 req_count;
  int                 setting_count;
  int                 phase;
  stall_mode_t        stall_mode;
  int                 stall_left;

  normal_cone_cull_test_core dut (.*);

  ncc_cull_checker u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: stall patterns picked at random from four modes.
  always @(posedge clk) begin
    if (stall_left <= 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(4, 48);
    end
    stall_left = stall_left - 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left < 12);
    endcase
  end

  function automatic cone_req_t mk_req(input ncc_pkg::op_t op,
                                       input int ax, ay, az, sp,
                                       input int cx, cy, cz,
                                       input int rad);
    cone_req_t r;
    r.op  = op;
    r.ax  = 16'(ax);
    r.ay  = 16'(ay);
    r.az  = 16'(az);
    r.sp  = 16'(sp);
    r.cx  = cx;
    r.cy  = cy;
    r.cz  = cz;
    r.rad = 31'(rad);
    return r;
  endfunction

  // A sphere placed along a near-unit axis from the viewpoint, so that the test
  // is close to its decision boundary.
  function automatic cone_req_t aligned_req();
    cone_req_t r;
    int        a [3];
    real       n;
    longint    k;
    longint    c;
    longint    dir;
    r.op = ncc_pkg::op_t'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) begin
      a = '{0, 0, 0};
      a[$urandom_range(0, 2)] = ($urandom_range(0, 1) == 1) ? 32766 : -32766;
    end else begin
      do begin
        for (int i = 0; i < 3; i++) begin
          a[i] = int'($urandom_range(0, 65532)) - 32766;
        end
        n = $sqrt(real'(a[0]) * a[0] + real'(a[1]) * a[1] + real'(a[2]) * a[2]);
      end while (n < 1000.0);
      for (int i = 0; i < 3; i++) begin
        a[i] = $rtoi(a[i] * 32766.0 / n);
      end
    end
    r.ax = 16'(a[0]);
    r.ay = 16'(a[1]);
    r.az = 16'(a[2]);
    // Short distances probe the minimum-f threshold, long ones the angle test.
    if ($urandom_range(0, 3) == 0) begin
      k = longint'($urandom_range(1, 4096));
    end else begin
      k = longint'($urandom_range(4096, 1 << 26));
    end
    dir = (r.op == ncc_pkg::OP_FRONTFACE) ? -1 : 1;
    for (int i = 0; i < 3; i++) begin
      c = longint'(view_cur[i]) + dir * longint'($rtoi(real'(k) * a[i] / 32766.0))
          + longint'(int'($urandom_range(0, 6)) - 3);
      if (i == 0) r.cx = c[31:0];
      else if (i == 1) r.cy = c[31:0];
      else r.cz = c[31:0];
    end
    r.rad = ($urandom_range(0, 3) == 0) ? 31'd0 : 31'($urandom_range(0, 32'(k + k / 4)));
    r.sp  = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(3276, 32760))
                                        : 16'($urandom_range(0, 32760));
    if ($urandom_range(0, 1) == 1) begin
      r.sp = -r.sp;
    end
    return r;
  endfunction

  // Unstructured requests: either fully random bits or a sphere near the viewpoint.
  function automatic cone_req_t noise_req();
    cone_req_t r;
    r.op = ncc_pkg::op_t'($urandom_range(0, 1));
    r.sp = 16'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      r.ax  = 16'($urandom);
      r.ay  = 16'($urandom);
      r.az  = 16'($urandom);
      r.cx  = $urandom;
      r.cy  = $urandom;
      r.cz  = $urandom;
      r.rad = 31'($urandom);
    end else begin
      r.ax  = 16'(int'($urandom_range(0, 65532)) - 32766);
      r.ay  = 16'(int'($urandom_range(0, 65532)) - 32766);
      r.az  = 16'(int'($urandom_range(0, 65532)) - 32766);
      r.cx  = view_cur[0] + (int'($urandom_range(0, 1 << 20)) - (1 << 19));
      r.cy  = view_cur[1] + (int'($urandom_range(0, 1 << 20)) - (1 << 19));
      r.cz  = view_cur[2] + (int'($urandom_range(0, 1 << 20)) - (1 << 19));
      r.rad = 31'($urandom_range(0, 1 << 20));
    end
    return r;
  endfunction

  // Present one request and hold it until accepted; bursts end in a random gap.
  task automatic send_req(input cone_req_t r);
    in_opcode   <= r.op;
    in_axis_x   <= r.ax;
    in_axis_y   <= r.ay;
    in_axis_z   <= r.az;
    in_spread   <= r.sp;
    in_centre_x <= r.cx;
    in_centre_y <= r.cy;
    in_centre_z <= r.cz;
    in_radius   <= r.rad;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    req_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic drain_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write all three viewpoint registers on consecutive cycles.
  task automatic set_view(input logic signed [31:0] vx, vy, vz);
    cfg_we    <= 1'b1;
    cfg_index <= ncc_pkg::CFG_VIEW_X;
    cfg_wdata <= vx;
    @(posedge clk);
    cfg_index <= ncc_pkg::CFG_VIEW_Y;
    cfg_wdata <= vy;
    @(posedge clk);
    cfg_index <= ncc_pkg::CFG_VIEW_Z;
    cfg_wdata <= vz;
    @(posedge clk);
    cfg_we      <= 1'b0;
    view_cur[0] = vx;
    view_cur[1] = vy;
    view_cur[2] = vz;
    setting_count++;
  endtask

  // Run limit.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = ncc_pkg::CFG_VIEW_X;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_opcode   = ncc_pkg::OP_BACKFACE;
    in_axis_x   = '0;
    in_axis_y   = '0;
    in_axis_z   = '0;
    in_spread   = '0;
    in_centre_x = '0;
    in_centre_y = '0;
    in_centre_z = '0;
    in_radius   = '0;
    view_cur    = '{0, 0, 0};
    burst_left  = 0;
    req_count   = 0;
    setting_count = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests against the reset viewpoint at the origin.
    // Just above and just below the minimum-f threshold.
    directed_q.push_back(mk_req(ncc_pkg::OP_BACKFACE, 32766, 0, 0, 3276, 66, 0, 0, 0));
    directed_q.push_back(mk_req(ncc_pkg::OP_BACKFACE, 32766, 0, 0, 3276, 65, 0, 0, 0));
    // Exact tie of f squared against d squared, for both test kinds.
    directed_q.push_back(mk_req(ncc_pkg::OP_BACKFACE, 32766, 0, 0, 3276, 655360, 0, 0, 0));
    directed_q.push_back(mk_req(ncc_pkg::OP_FRONTFACE, 32766, 0, 0, 3276,
                                -655360, 0, 0, 0));
    // The radius alone sets the anchor offset in the first two; the third uses a negative axis.
    directed_q.push_back(mk_req(ncc_pkg::OP_FRONTFACE, 0, 32766, 0, -3276,
                                0, 0, 0, 655360));
    directed_q.push_back(mk_req(ncc_pkg::OP_FRONTFACE, 0, 32766, 0, 3276,
                                0, 0, 0, 655360));
    directed_q.push_back(mk_req(ncc_pkg::OP_BACKFACE, -32766, 0, 0, 3276,
                                -655360, 0, 0, 0));
    // Zero spread and a zero axis can never pass.
    directed_q.push_back(mk_req(ncc_pkg::OP_BACKFACE, 32766, 0, 0, 0, 655360, 0, 0, 0));
    directed_q.push_back(mk_req(ncc_pkg::OP_FRONTFACE, 0, 0, 0, 32760,
                                655360, 1, -1, 100));
    // Spread and axis codes at and past the encoded range.
    directed_q.push_back(mk_req(ncc_pkg::OP_BACKFACE, 0, 0, 32766, 32760,
                                0, 0, 32'sh7fffffff, 0));
    directed_q.push_back(mk_req(ncc_pkg::OP_BACKFACE, 0, 0, -32766, -32760,
                                0, 0, 32'sh7fffffff, 0));
    directed_q.push_back(mk_req(ncc_pkg::OP_BACKFACE, -32768, -32768, -32768, 32767,
                                32'sh80000000, 32'sh80000000, 32'sh80000000,
                                32'h7fffffff));
    directed_q.push_back(mk_req(ncc_pkg::OP_FRONTFACE, -32767, 32767, -32766, -32768,
                                32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                32'h7fffffff));
    // Largest radius against the largest centres, then a diagonal axis.
    directed_q.push_back(mk_req(ncc_pkg::OP_BACKFACE, 0, 0, 32766, 32760,
                                32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                32'h7fffffff));
    directed_q.push_back(mk_req(ncc_pkg::OP_FRONTFACE, 0, 0, -32766, 32760,
                                32'sh80000000, 32'sh80000000, 32'sh80000000,
                                32'h7fffffff));
    directed_q.push_back(mk_req(ncc_pkg::OP_BACKFACE, 18918, 18918, 18918, 16380,
                                1 << 24, 1 << 24, 1 << 24, 1 << 20));
    foreach (directed_q[i]) begin
      send_req(directed_q[i]);
    end
    drain_idle();

    // Random phases, each under its own viewpoint, extremes first.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: set_view(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        1: set_view(32'sh80000000, 32'sh80000000, 32'sh80000000);
        2: set_view(32'sh7fffffff, 32'sh80000000, 0);
        3: set_view(int'($urandom_range(0, 1 << 21)) - (1 << 20),
                    int'($urandom_range(0, 1 << 21)) - (1 << 20),
                    int'($urandom_range(0, 1 << 21)) - (1 << 20));
        4: set_view(0, 0, 0);
        default: set_view($urandom, $urandom, $urandom);
      endcase
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 7) begin
          send_req(aligned_req());
        end else begin
          send_req(noise_req());
        end
      end
      drain_idle();
    end

    $display("Sent %0d cull requests under %0d viewpoint settings.", req_count, setting_count);
    $display("Checked %0d results, %0d of them facing.", result_count, facing_count);
    if (err_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ncc_pkg.sv
rtl/ncc_ctrl.sv
rtl/ncc_geom.sv
rtl/ncc_wide.sv
rtl/normal_cone_cull_test_core.sv
verif/ncc_cull_checker.sv
verif/tb_normal_cone_cull_test_core.sv
